@@ rtl/amt_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package amt_pkg;

    typedef enum logic [2:0] {
        MODE_ADD_VERTEX    = 3'd0,
        MODE_REMOVE_VERTEX = 3'd1,
        MODE_ADD_EDGE      = 3'd2,
        MODE_REMOVE_EDGE   = 3'd3,
        MODE_READ_ROW      = 3'd4
    } t_mode;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_READ_WAIT,
        ST_EDGE_A,
        ST_EDGE_B,
        ST_SWEEP,
        ST_RESP
    } t_state;

    typedef struct packed {
        logic load;
        logic add_vertex;
        logic capture_read;
        logic edge_wr_a;
        logic edge_wr_b;
        logic sweep_start;
        logic sweep_step;
        logic remove_done;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic [2:0] mode;
        logic       add_ok;
        logic       index_ok;
        logic       edge_ok;
        logic       single;
        logic       sweep_last;
        logic       out_free;
    } t_status;

endpackage

`default_nettype wire

@@ rtl/adjacency_matrix_table.sv @@
// Sequence: every command is loaded, then decoded; read row waits for the memory read,
// add and remove edge write both rows, remove vertex sweeps, and then the result is registered.
// Commands are taken one at a time; the next is taken once the result is registered.
// Remove vertex moves one row and one value per cycle through the single read port
// of the row and value memories.
// Reset clears the vertex count and control; the memories are not cleared.
`timescale 1ns / 1ps
`default_nettype none

module adjacency_matrix_table #(
    parameter int MAX_VERTICES = 32
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_ready,
    input  wire logic [2:0]         i_mode,
    input  wire logic signed [31:0] i_vertex_value,
    input  wire logic [5:0]         i_index_a,
    input  wire logic [5:0]         i_index_b,
    output logic                    o_valid,
    input  wire logic               i_ready,
    output logic                    o_accepted,
    output logic [5:0]              o_vertex_count,
    output logic [31:0]             o_row_bits,
    output logic signed [31:0]      o_row_value
);

    import amt_pkg::*;

    t_cmd    cmd;
    t_status status;

    amt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_valid),
        .o_in_ready (o_ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    amt_datapath #(
        .MAX_VERTICES (MAX_VERTICES)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_mode         (i_mode),
        .i_vertex_value (i_vertex_value),
        .i_index_a      (i_index_a),
        .i_index_b      (i_index_b),
        .i_cmd          (cmd),
        .o_status       (status),
        .i_out_ready    (i_ready),
        .o_out_valid    (o_valid),
        .o_accepted     (o_accepted),
        .o_vertex_count (o_vertex_count),
        .o_row_bits     (o_row_bits),
        .o_row_value    (o_row_value)
    );

endmodule

`default_nettype wire

@@ rtl/amt_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none

module amt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

@@ rtl/amt_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none

module amt_ctrl (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_in_valid,
    output logic                 o_in_ready,
    input  wire amt_pkg::t_status i_status,
    output amt_pkg::t_cmd        o_cmd
);

    import amt_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_DECODE;
                end
            end
            ST_DECODE: begin
                n_state = ST_RESP;
                case (i_status.mode)
                    MODE_REMOVE_VERTEX: begin
                        if (i_status.index_ok && !i_status.single) begin
                            n_state = ST_SWEEP;
                        end
                    end
                    MODE_ADD_EDGE, MODE_REMOVE_EDGE: begin
                        if (i_status.edge_ok) begin
                            n_state = ST_EDGE_A;
                        end
                    end
                    MODE_READ_ROW: begin
                        if (i_status.index_ok) begin
                            n_state = ST_READ_WAIT;
                        end
                    end
                    default: n_state = ST_RESP;
                endcase
            end
            ST_READ_WAIT: n_state = ST_RESP;
            ST_EDGE_A:    n_state = ST_EDGE_B;
            ST_EDGE_B:    n_state = ST_RESP;
            ST_SWEEP: begin
                if (i_status.sweep_last) begin
                    n_state = ST_RESP;
                end
            end
            ST_RESP: begin
                if (i_status.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            ST_DECODE: begin
                case (i_status.mode)
                    MODE_ADD_VERTEX: begin
                        o_cmd.add_vertex = i_status.add_ok;
                    end
                    MODE_REMOVE_VERTEX: begin
                        if (i_status.index_ok) begin
                            // A lone vertex leaves no rows to move.
                            o_cmd.remove_done = i_status.single;
                            o_cmd.sweep_start = !i_status.single;
                        end
                    end
                    default: o_cmd = '0;
                endcase
            end
            ST_READ_WAIT: o_cmd.capture_read = 1'b1;
            ST_EDGE_A:    o_cmd.edge_wr_a = 1'b1;
            ST_EDGE_B:    o_cmd.edge_wr_b = 1'b1;
            ST_SWEEP: begin
                o_cmd.sweep_step  = 1'b1;
                o_cmd.remove_done = i_status.sweep_last;
            end
            ST_RESP: o_cmd.emit = i_status.out_free;
            default: o_cmd = '0;
        endcase
    end

endmodule

`default_nettype wire

@@ rtl/amt_datapath.sv @@
`timescale 1ns / 1ps
`default_nettype none

module amt_datapath #(
    parameter int MAX_VERTICES = 32
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic [2:0]      i_mode,
    input  wire logic [31:0]     i_vertex_value,
    input  wire logic [5:0]      i_index_a,
    input  wire logic [5:0]      i_index_b,
    input  wire amt_pkg::t_cmd   i_cmd,
    output amt_pkg::t_status     o_status,
    input  wire logic            i_out_ready,
    output logic                 o_out_valid,
    output logic                 o_accepted,
    output logic [5:0]           o_vertex_count,
    output logic [31:0]          o_row_bits,
    output logic signed [31:0]   o_row_value
);

    import amt_pkg::*;

    localparam int AW = $clog2(MAX_VERTICES);
    localparam int CW = $clog2(MAX_VERTICES + 1);
    localparam int XW = (CW > 6) ? CW : 6;
    localparam int RW = (MAX_VERTICES > 32) ? MAX_VERTICES : 32;

    // Command registers.
    logic [2:0]               r_mode;
    logic [31:0]              r_val;
    logic [5:0]               r_a;
    logic [5:0]               r_b;

    logic [CW-1:0]            r_count;
    logic [CW-1:0]            r_idx;

    logic                     r_acc;
    logic [31:0]              r_res_bits;
    logic [31:0]              r_res_val;

    logic                     r_out_valid;
    logic                     r_o_acc;
    logic [5:0]               r_o_count;
    logic [31:0]              r_o_bits;
    logic [31:0]              r_o_val;

    // Memory ports.
    logic                     row_we;
    logic [AW-1:0]            row_waddr;
    logic [MAX_VERTICES-1:0]  row_wdata;
    logic [MAX_VERTICES-1:0]  row_rdata;
    logic                     val_we;
    logic [AW-1:0]            val_waddr;
    logic [31:0]              val_wdata;
    logic [31:0]              val_rdata;
    logic [AW-1:0]            raddr;

    logic [MAX_VERTICES-1:0]  edge_mask;
    logic [MAX_VERTICES-1:0]  dropped;
    logic [MAX_VERTICES:0]    row_ext;
    logic [RW-1:0]            row_wide;
    logic [CW-1:0]            idx_next;
    logic [CW-1:0]            src_first;
    logic [CW-1:0]            src_next;
    logic                     a_ok;
    logic                     b_ok;

    assign a_ok = XW'(r_a) < XW'(r_count);
    assign b_ok = XW'(r_b) < XW'(r_count);

    always_comb begin
        o_status            = '0;
        o_status.mode       = r_mode;
        o_status.add_ok     = r_count != CW'(MAX_VERTICES);
        o_status.index_ok   = a_ok;
        o_status.edge_ok    = a_ok && b_ok && (r_a != r_b);
        o_status.single     = r_count == CW'(1);
        o_status.sweep_last = r_idx == (r_count - CW'(2));
        o_status.out_free   = !r_out_valid || i_out_ready;
    end

    // Row i of the compacted matrix comes from row i, or from row i + 1 at
    // and above the removed vertex.
    assign idx_next  = r_idx + CW'(1);
    assign src_first = (XW'(r_a) == XW'(0)) ? CW'(1) : CW'(0);
    assign src_next  = (XW'(idx_next) < XW'(r_a)) ? idx_next : idx_next + CW'(1);

    assign edge_mask = MAX_VERTICES'(1) << (i_cmd.edge_wr_a ? r_b[AW-1:0] : r_a[AW-1:0]);

    // Drop the removed vertex's column: bits above it move down by one.
    assign row_ext = {1'b0, row_rdata};
    always_comb begin
        for (int j = 0; j < MAX_VERTICES; j++) begin
            dropped[j] = (j < int'(r_a)) ? row_ext[j] : row_ext[j + 1];
        end
    end

    assign row_wide = RW'(row_rdata);

    always_comb begin
        row_we    = 1'b0;
        row_waddr = r_a[AW-1:0];
        row_wdata = '0;
        val_we    = 1'b0;
        val_waddr = r_count[AW-1:0];
        val_wdata = r_val;
        raddr     = r_a[AW-1:0];
        if (i_cmd.add_vertex) begin
            row_we    = 1'b1;
            row_waddr = r_count[AW-1:0];
            row_wdata = '0;
            val_we    = 1'b1;
        end
        if (i_cmd.edge_wr_a || i_cmd.edge_wr_b) begin
            row_we    = 1'b1;
            row_waddr = i_cmd.edge_wr_a ? r_a[AW-1:0] : r_b[AW-1:0];
            row_wdata = (r_mode == MODE_ADD_EDGE) ? (row_rdata | edge_mask)
                                                   : (row_rdata & ~edge_mask);
            raddr     = r_b[AW-1:0];
        end
        if (i_cmd.sweep_start) begin
            raddr = src_first[AW-1:0];
        end
        if (i_cmd.sweep_step) begin
            row_we    = 1'b1;
            row_waddr = r_idx[AW-1:0];
            row_wdata = dropped;
            val_we    = 1'b1;
            val_waddr = r_idx[AW-1:0];
            val_wdata = val_rdata;
            raddr     = src_next[AW-1:0];
        end
    end

    amt_ram #(
        .WIDTH (MAX_VERTICES),
        .DEPTH (MAX_VERTICES)
    ) u_row_ram (
        .i_clk   (i_clk),
        .i_we    (row_we),
        .i_waddr (row_waddr),
        .i_wdata (row_wdata),
        .i_raddr (raddr),
        .o_rdata (row_rdata)
    );

    amt_ram #(
        .WIDTH (32),
        .DEPTH (MAX_VERTICES)
    ) u_val_ram (
        .i_clk   (i_clk),
        .i_we    (val_we),
        .i_waddr (val_waddr),
        .i_wdata (val_wdata),
        .i_raddr (raddr),
        .o_rdata (val_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mode <= i_mode;
            r_val  <= i_vertex_value;
            r_a    <= i_index_a;
            r_b    <= i_index_b;
        end
        if (i_cmd.sweep_start) begin
            r_idx <= '0;
        end else if (i_cmd.sweep_step) begin
            r_idx <= idx_next;
        end
        if (i_cmd.load) begin
            r_res_bits <= '0;
            r_res_val  <= '0;
        end else if (i_cmd.capture_read) begin
            r_res_bits <= row_wide[31:0];
            r_res_val  <= val_rdata;
        end
        if (i_cmd.emit) begin
            r_o_acc   <= r_acc;
            r_o_count <= 6'(r_count);
            r_o_bits  <= r_res_bits;
            r_o_val   <= r_res_val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_acc       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.add_vertex) begin
                r_count <= r_count + CW'(1);
            end else if (i_cmd.remove_done) begin
                r_count <= r_count - CW'(1);
            end
            if (i_cmd.load) begin
                r_acc <= 1'b0;
            end else if (i_cmd.add_vertex || i_cmd.capture_read || i_cmd.edge_wr_b
                         || i_cmd.remove_done) begin
                r_acc <= 1'b1;
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_accepted     = r_o_acc;
    assign o_vertex_count = r_o_count;
    assign o_row_bits     = r_o_bits;
    assign o_row_value    = r_o_val;

endmodule

`default_nettype wire

@@ rtl/amt_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none

module amt_checker #(
    parameter int MAX_VERTICES = 32
) (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_valid,
    input wire logic        o_ready,
    input wire logic        o_valid,
    input wire logic        i_ready,
    input wire logic        o_accepted,
    input wire logic [5:0]  o_vertex_count,
    input wire logic [31:0] o_row_bits,
    input wire logic [31:0] o_row_value
);

    // A stalled result must stay on the port.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_row_bits) && $stable(o_row_value))
        else $error("result dropped or changed while stalled");

    // An ignored command shows zero row fields.
    a_ignored_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_accepted |-> o_row_bits == 32'd0 && o_row_value == 32'd0)
        else $error("ignored command returned row data");

    // The count never goes beyond the store size.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> 7'(o_vertex_count) <= 7'(MAX_VERTICES))
        else $error("vertex count beyond store size");

    // Commands are taken one at a time.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
        else $error("second command taken while one is in progress");

endmodule

bind adjacency_matrix_table amt_checker #(
    .MAX_VERTICES (MAX_VERTICES)
) u_amt_checker (.*);

`default_nettype wire
